FILE: rtl/core/running_median_rate_defines.svh
// ----------------------------------------------------------------------------
// running_median_rate_defines.svh
// Assertion macros shared by the checker of the running median rate block.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_RATE_DEFINES_SVH
`define RUNNING_MEDIAN_RATE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define RMR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RMR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rmr_pkg.sv
// ----------------------------------------------------------------------------
// rmr_pkg
// Shared constants, state types and control structures of the running
// median rate block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmr_pkg;

  localparam int DATA_W     = 32;
  localparam int RATE_W     = 20;
  localparam int WINDOW_DEF = 32;

  localparam logic [DATA_W-1:0] RATE_SCALE = 32'd1000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_MERGE_GO,
    ST_MERGE_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } top_state_t;

  typedef enum logic [1:0] {
    MG_IDLE,
    MG_READ,
    MG_EXAMINE,
    MG_TAIL
  } merge_state_t;

  typedef struct packed {
    logic start;
    logic drop;
  } merge_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/running_median_rate.sv
// ----------------------------------------------------------------------------
// running_median_rate
// Frame rate from the running upper median of the last WINDOW frame times.
// ----------------------------------------------------------------------------
// A frame time of zero goes straight to the finish state, is offered as a
// rate of zero and changes nothing. A nonzero frame time enters a ring of
// WINDOW entries and a sorted copy of the window, which is rebuilt by one
// streaming pass that reads and then examines each stored entry through a
// simple dual-port memory; the rounded quotient (1000000 + median/2) / median
// then comes from a restoring divider at one bit per cycle. The block takes
// no new transaction until the result has been placed in the output register.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module running_median_rate #(
  parameter int WINDOW = rmr_pkg::WINDOW_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       sample_valid,
  output logic                            sample_ready,
  input  wire logic [rmr_pkg::DATA_W-1:0] frame_time_us,
  output logic                            rate_valid,
  input  wire logic                       rate_ready,
  output logic [rmr_pkg::RATE_W-1:0]      rate_per_second
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  rmr_pkg::top_state_t state, state_next;

  logic [rmr_pkg::DATA_W-1:0] sample;
  logic [AW-1:0]              slot;
  logic [CW-1:0]              fill;
  logic                       full;
  logic [rmr_pkg::DATA_W-1:0] ring_mem [WINDOW];
  logic [rmr_pkg::DATA_W-1:0] ring_q;
  logic [rmr_pkg::RATE_W-1:0] result;

  rmr_pkg::merge_ctl_t        merge_ctl;
  logic                       merge_done;
  logic [rmr_pkg::DATA_W-1:0] median;
  logic                       div_start;
  logic                       div_done;
  logic [rmr_pkg::DATA_W-1:0] dividend;
  logic [rmr_pkg::RATE_W-1:0] quotient;
  logic                       accept;
  logic                       out_load;

  assign full     = (fill == CW'(WINDOW));
  assign accept   = sample_valid && sample_ready;
  assign dividend = rmr_pkg::RATE_SCALE + {1'b0, median[rmr_pkg::DATA_W-1:1]};

  rmr_merge #(
    .WINDOW (WINDOW)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .ctl     (merge_ctl),
    .n_old   (fill),
    .old_val (ring_q),
    .new_val (sample),
    .done    (merge_done),
    .median  (median)
  );

  rmr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (median),
    .done     (div_done),
    .quotient (quotient)
  );

  // The ring read returns the entry about to be overwritten.
  always_ff @(posedge clk) begin
    if (state == rmr_pkg::ST_RING) begin
      ring_q         <= ring_mem[slot];
      ring_mem[slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rmr_pkg::ST_IDLE;
      slot       <= '0;
      fill       <= '0;
      rate_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rmr_pkg::ST_MERGE_GO) begin
        slot <= (slot == AW'(WINDOW - 1)) ? '0 : slot + 1'b1;
        if (!full) begin
          fill <= fill + 1'b1;
        end
      end
      if (out_load) begin
        rate_valid <= 1'b1;
      end else if (rate_ready) begin
        rate_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= frame_time_us;
      result <= '0;
    end else if (state == rmr_pkg::ST_DIV_WAIT && div_done) begin
      result <= quotient;
    end
    if (out_load) begin
      rate_per_second <= result;
    end
  end

  always_comb begin
    state_next      = state;
    sample_ready    = 1'b0;
    merge_ctl.start = 1'b0;
    merge_ctl.drop  = full;
    div_start       = 1'b0;
    out_load        = 1'b0;
    case (state)
      rmr_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = (frame_time_us == '0) ? rmr_pkg::ST_FINISH : rmr_pkg::ST_RING;
        end
      end
      rmr_pkg::ST_RING: begin
        state_next = rmr_pkg::ST_MERGE_GO;
      end
      rmr_pkg::ST_MERGE_GO: begin
        merge_ctl.start = 1'b1;
        state_next      = rmr_pkg::ST_MERGE_WAIT;
      end
      rmr_pkg::ST_MERGE_WAIT: begin
        if (merge_done) begin
          state_next = rmr_pkg::ST_DIV_GO;
        end
      end
      rmr_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = rmr_pkg::ST_DIV_WAIT;
      end
      rmr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = rmr_pkg::ST_FINISH;
        end
      end
      rmr_pkg::ST_FINISH: begin
        if (!rate_valid || rate_ready) begin
          out_load   = 1'b1;
          state_next = rmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/rmr_divider.sv
// ----------------------------------------------------------------------------
// rmr_divider
// Restoring divider with one shared subtract and compare unit, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmr_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rmr_pkg::DATA_W-1:0] dividend,
  input  wire logic [rmr_pkg::DATA_W-1:0] divisor,
  output logic                            done,
  output logic [rmr_pkg::RATE_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(rmr_pkg::DATA_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [rmr_pkg::DATA_W-1:0] rem;
  logic [rmr_pkg::DATA_W-1:0] dvd;
  logic [rmr_pkg::DATA_W-1:0] dsr;
  logic [rmr_pkg::DATA_W:0]   rem_sh;
  logic [rmr_pkg::DATA_W:0]   rem_sub;
  logic                       ge;

  always_comb begin
    rem_sh  = {rem, dvd[rmr_pkg::DATA_W-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    ge      = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(rmr_pkg::DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift in behind the dividend bits as they are consumed.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? rem_sub[rmr_pkg::DATA_W-1:0] : rem_sh[rmr_pkg::DATA_W-1:0];
      dvd <= {dvd[rmr_pkg::DATA_W-2:0], ge};
    end
  end

  assign quotient = dvd[rmr_pkg::RATE_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/rmr_merge.sv
// ----------------------------------------------------------------------------
// rmr_merge
// Keeps the window contents as a sorted list in a two-bank memory. Each
// update streams the list from one bank to the other, dropping the evicted
// value and inserting the new one, and captures the upper median on the way.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmr_merge #(
  parameter int WINDOW = rmr_pkg::WINDOW_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rmr_pkg::merge_ctl_t        ctl,
  input  wire logic [$clog2(WINDOW+1)-1:0] n_old,
  input  wire logic [rmr_pkg::DATA_W-1:0] old_val,
  input  wire logic [rmr_pkg::DATA_W-1:0] new_val,
  output logic                            done,
  output logic [rmr_pkg::DATA_W-1:0]      median
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  rmr_pkg::merge_state_t state, state_next;

  logic                       bank;
  logic [CW-1:0]              rd;
  logic [CW-1:0]              wr;
  logic [CW-1:0]              n_reg;
  logic [CW-1:0]              k;
  logic [CW-1:0]              n_new;
  logic                       drop_pend;
  logic                       inserted;
  logic [rmr_pkg::DATA_W-1:0] old_r;
  logic [rmr_pkg::DATA_W-1:0] new_r;

  logic [rmr_pkg::DATA_W-1:0] sort_mem [2**(AW+1)];
  logic [rmr_pkg::DATA_W-1:0] rd_data;
  logic [AW:0]                rd_addr;
  logic [AW:0]                wr_addr;

  logic                       we;
  logic [rmr_pkg::DATA_W-1:0] wdata;
  logic                       rd_inc;
  logic                       wr_inc;
  logic                       ins_set;
  logic                       drop_clr;

  assign rd_addr = {bank, rd[AW-1:0]};
  assign wr_addr = {~bank, wr[AW-1:0]};
  assign n_new   = ctl.drop ? n_old : n_old + 1'b1;

  always_ff @(posedge clk) begin
    rd_data <= sort_mem[rd_addr];
    if (we) begin
      sort_mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmr_pkg::MG_IDLE;
      bank  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rmr_pkg::MG_TAIL) begin
        bank <= ~bank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rmr_pkg::MG_IDLE && ctl.start) begin
      n_reg     <= n_old;
      k         <= n_new >> 1;
      drop_pend <= ctl.drop;
      inserted  <= 1'b0;
      old_r     <= old_val;
      new_r     <= new_val;
      rd        <= '0;
      wr        <= '0;
    end else begin
      if (rd_inc)   rd        <= rd + 1'b1;
      if (wr_inc)   wr        <= wr + 1'b1;
      if (ins_set)  inserted  <= 1'b1;
      if (drop_clr) drop_pend <= 1'b0;
    end
    if (we && wr == k) begin
      median <= wdata;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    wdata      = rd_data;
    rd_inc     = 1'b0;
    wr_inc     = 1'b0;
    ins_set    = 1'b0;
    drop_clr   = 1'b0;
    done       = 1'b0;
    case (state)
      rmr_pkg::MG_IDLE: begin
        if (ctl.start) begin
          state_next = rmr_pkg::MG_READ;
        end
      end
      rmr_pkg::MG_READ: begin
        state_next = (rd == n_reg) ? rmr_pkg::MG_TAIL : rmr_pkg::MG_EXAMINE;
      end
      rmr_pkg::MG_EXAMINE: begin
        state_next = rmr_pkg::MG_READ;
        if (drop_pend && rd_data == old_r) begin
          // The first copy of the evicted value is skipped.
          drop_clr = 1'b1;
          rd_inc   = 1'b1;
        end else if (!inserted && rd_data > new_r) begin
          // The new value goes in ahead; the same element is read again.
          we      = 1'b1;
          wdata   = new_r;
          wr_inc  = 1'b1;
          ins_set = 1'b1;
        end else begin
          we     = 1'b1;
          wr_inc = 1'b1;
          rd_inc = 1'b1;
        end
      end
      rmr_pkg::MG_TAIL: begin
        if (!inserted) begin
          we    = 1'b1;
          wdata = new_r;
        end
        done       = 1'b1;
        state_next = rmr_pkg::MG_IDLE;
      end
      default: begin
        state_next = rmr_pkg::MG_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/running_median_rate_checker.sv
// ----------------------------------------------------------------------------
// running_median_rate_checker
// Port-level checks of the running median rate block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "running_median_rate_defines.svh"

module running_median_rate_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       sample_valid,
  input wire logic                       sample_ready,
  input wire logic                       rate_valid,
  input wire logic                       rate_ready,
  input wire logic [rmr_pkg::RATE_W-1:0] rate_per_second
);

  // A result that has not been taken stays offered.
  `RMR_ASSERT_NEXT(a_rate_held, clk, rst, rate_valid && !rate_ready, rate_valid, "rate dropped")

  // No median frame time can give more than one million per second.
  `RMR_ASSERT_NOW(a_rate_range, clk, rst, rate_valid, rate_per_second <= 20'd1000000, "rate range")

  // The block works on one transaction at a time.
  `RMR_ASSERT_NEXT(a_busy_after, clk, rst, sample_valid && sample_ready, !sample_ready, "not busy")

  // Leaving reset, the block is idle with nothing on its output.
  `RMR_ASSERT_NOW(a_reset_clean, clk, rst, $past(rst), sample_ready && !rate_valid, "reset state")

endmodule

bind running_median_rate running_median_rate_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .sample_valid    (sample_valid),
  .sample_ready    (sample_ready),
  .rate_valid      (rate_valid),
  .rate_ready      (rate_ready),
  .rate_per_second (rate_per_second)
);

`default_nettype wire

FILE: bench/running_median_rate_test.sv
// ----------------------------------------------------------------------------
// running_median_rate_test
// Self-checking bench for the running median frame rate block.
// ----------------------------------------------------------------------------
// Frame times are offered on the sample channel and rates are collected on
// the rate channel, both with random idle cycles. A scoreboard keeps its own
// ring of frame times and works out the rounded rate of the upper median
// for every accepted sample. A short directed run covers the corner values,
// and a long random run follows. Each rate that arrives is compared with the
// oldest expected rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_median_rate_test;

  localparam int DEPTH       = rmr_pkg::WINDOW_DEF;
  localparam int RANDOM_RUN  = 1130;
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AT     = 400;
  localparam int DRAIN_TAIL  = 150;

  // Scoreboard: a private copy of the frame time ring and the rates due.
  class rate_book;
    logic [rmr_pkg::DATA_W-1:0] ring[DEPTH];
    int                         slot;
    int                         fill;
    int                         errors;
    logic [rmr_pkg::RATE_W-1:0] rates_due[$];

    function new();
      slot   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function logic [rmr_pkg::DATA_W-1:0] upper_median();
      logic [rmr_pkg::DATA_W-1:0] sorted[DEPTH];
      logic [rmr_pkg::DATA_W-1:0] v;
      int                         i;
      int                         j;
      for (i = 0; i < fill; i++) begin
        v = ring[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[fill/2];
    endfunction

    function void note_sample(logic [rmr_pkg::DATA_W-1:0] t);
      logic [63:0] m;
      logic [63:0] q;
      if (t == '0) begin
        rates_due.insert(rates_due.size(), '0);
      end else begin
        ring[slot] = t;
        slot = (slot + 1) % DEPTH;
        if (fill < DEPTH) fill++;
        m = 64'(upper_median());
        q = (64'(rmr_pkg::RATE_SCALE) + m / 2) / m;
        rates_due.insert(rates_due.size(), q[rmr_pkg::RATE_W-1:0]);
      end
    endfunction

    function void check_rate(logic [rmr_pkg::RATE_W-1:0] got);
      logic [rmr_pkg::RATE_W-1:0] want;
      if (rates_due.size() == 0) begin
        $error("rate_per_second: no rate expected, got %0d", got);
        errors++;
      end else begin
        want = rates_due.pop_front();
        if (got !== want) begin
          $error("rate_per_second: expected %0d, got %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return rates_due.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       sample_valid;
  logic                       sample_ready;
  logic [rmr_pkg::DATA_W-1:0] frame_time_us;
  logic                       rate_valid;
  logic                       rate_ready;
  logic [rmr_pkg::RATE_W-1:0] rate_per_second;

  rate_book book;
  int       samples_sent;
  int       rates_taken;
  int       idle_cycles;

  running_median_rate DUT (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_ready    (sample_ready),
    .frame_time_us   (frame_time_us),
    .rate_valid      (rate_valid),
    .rate_ready      (rate_ready),
    .rate_per_second (rate_per_second)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called on a falling edge; returns on the falling edge after acceptance.
  task automatic send_sample(input logic [rmr_pkg::DATA_W-1:0] t);
    int gap;
    gap = ((samples_sent % 200) < 40) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid  = 1'b1;
    frame_time_us = t;
    do @(posedge clk); while (!sample_ready);
    book.note_sample(t);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic take_rates();
    int gap;
    forever begin
      if (rates_taken == HOLD_AT) begin
        gap = LONG_HOLD;
      end else begin
        gap = ((rates_taken % 150) < 30) ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        rate_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rate_ready = 1'b1;
      do @(posedge clk); while (!rate_valid);
      book.check_rate(rate_per_second);
      rates_taken++;
      @(negedge clk);
    end
  endtask

  task automatic wait_for_rates();
    while (book.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [rmr_pkg::DATA_W-1:0] pick_frame_time(
    input logic [rmr_pkg::DATA_W-1:0] base
  );
    int kind;
    kind = $urandom_range(0, 11);
    case (kind)
      0:       return '0;
      1:       return $urandom();
      2:       return $urandom_range(1, 8);
      3:       return $urandom_range(1999990, 2000010);
      4:       return {2'($urandom_range(1, 3)), 30'($urandom())};
      default: return base + $urandom_range(0, 4000);
    endcase
  endfunction

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((sample_valid && sample_ready) || (rate_valid && rate_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("running_median_rate_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [rmr_pkg::DATA_W-1:0] directed_times[$];
    logic [rmr_pkg::DATA_W-1:0] base;
    int                         i;

    book          = new();
    samples_sent  = 0;
    rates_taken   = 0;
    rst           = 1'b1;
    sample_valid  = 1'b0;
    frame_time_us = '0;
    rate_ready    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    fork
      take_rates();
    join_none

    // Zero before any sample, a median of one, the widest frame times, the
    // edges where the rounded rate drops from one to zero, and alternating
    // bit patterns.
    directed_times = '{32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'd2000000, 32'd2000001, 32'd1, 32'd16667, 32'd33333,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'd3, 32'd0, 32'd1000,
                       32'd999999, 32'h0000_FFFF, 32'hFFFF_0000,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'd2};
    foreach (directed_times[k]) send_sample(directed_times[k]);
    sample_valid = 1'b0;

    // Let the block empty completely before the random run.
    wait_for_rates();

    base = 32'd16000;
    for (i = 0; i < RANDOM_RUN; i++) begin
      if ((i % 100) == 0) base = $urandom_range(1000, 80000);
      send_sample(pick_frame_time(base));
    end
    sample_valid = 1'b0;

    wait_for_rates();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("running_median_rate_test: done, clean");
    end else begin
      $display("running_median_rate_test: done, errors");
    end
    $finish;
  end

endmodule
